// ===== design/assert_macros.svh =====
// Assertion macros shared by the stack controller and datapath.
// Depends on i_clk and i_rst_n being visible in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lifo_pkg.sv =====
// Shared types and constants for the LIFO stack with reverse and delete-middle.
// No dependencies.
`default_nettype none

package lifo_pkg;

    localparam int DEPTH = 16;
    localparam int WIDTH = 32;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 32;
    localparam int ENTRY_W  = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH    = 2'd0,
        ACT_POP     = 2'd1,
        ACT_REVERSE = 2'd2,
        ACT_DELMID  = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REV_CHK,
        S_REV_RHI,
        S_REV_WLO,
        S_REV_WHI,
        S_DEL_CHK,
        S_DEL_WR,
        S_TOP_RD,
        S_FIN
    } t_state;

    typedef struct packed {
        logic accept;
        logic rev_read_lo;
        logic rev_read_hi;
        logic rev_write_lo;
        logic rev_write_hi;
        logic del_read;
        logic del_write;
        logic del_drop;
        logic top_read;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic rev_more;
        logic del_more;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== design/lifo_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lifo_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/lifo_ctrl.sv =====
// Controller state machine for the LIFO stack.
// Depends on lifo_pkg and assert_macros.svh.
`default_nettype none

module lifo_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire logic [lifo_pkg::ACTION_W-1:0] i_action,
    output logic                              o_in_ready,
    input  wire lifo_pkg::t_stat              i_stat,
    output lifo_pkg::t_cmd                    o_cmd
);

    lifo_pkg::t_state r_state;
    lifo_pkg::t_state n_state;
    lifo_pkg::t_action action;
    logic accept;

    assign action = lifo_pkg::t_action'(i_action);
    assign o_in_ready = (r_state == lifo_pkg::S_IDLE);
    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lifo_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lifo_pkg::S_IDLE: begin
                if (accept) begin
                    case (action)
                        lifo_pkg::ACT_REVERSE: begin
                            n_state = i_stat.count_zero ? lifo_pkg::S_TOP_RD
                                                        : lifo_pkg::S_REV_CHK;
                        end
                        lifo_pkg::ACT_DELMID: begin
                            n_state = i_stat.count_zero ? lifo_pkg::S_TOP_RD
                                                        : lifo_pkg::S_DEL_CHK;
                        end
                        default: begin
                            n_state = lifo_pkg::S_TOP_RD;
                        end
                    endcase
                end
            end
            lifo_pkg::S_REV_CHK: begin
                n_state = i_stat.rev_more ? lifo_pkg::S_REV_RHI : lifo_pkg::S_TOP_RD;
            end
            lifo_pkg::S_REV_RHI: n_state = lifo_pkg::S_REV_WLO;
            lifo_pkg::S_REV_WLO: n_state = lifo_pkg::S_REV_WHI;
            lifo_pkg::S_REV_WHI: n_state = lifo_pkg::S_REV_CHK;
            lifo_pkg::S_DEL_CHK: begin
                n_state = i_stat.del_more ? lifo_pkg::S_DEL_WR : lifo_pkg::S_TOP_RD;
            end
            lifo_pkg::S_DEL_WR: n_state = lifo_pkg::S_DEL_CHK;
            lifo_pkg::S_TOP_RD: n_state = lifo_pkg::S_FIN;
            lifo_pkg::S_FIN: begin
                if (i_stat.out_free) begin
                    n_state = lifo_pkg::S_IDLE;
                end
            end
            default: n_state = lifo_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            lifo_pkg::S_IDLE:    o_cmd.accept = accept;
            lifo_pkg::S_REV_CHK: begin
                o_cmd.rev_read_lo = i_stat.rev_more;
            end
            lifo_pkg::S_REV_RHI: o_cmd.rev_read_hi = 1'b1;
            lifo_pkg::S_REV_WLO: o_cmd.rev_write_lo = 1'b1;
            lifo_pkg::S_REV_WHI: o_cmd.rev_write_hi = 1'b1;
            lifo_pkg::S_DEL_CHK: begin
                o_cmd.del_read = i_stat.del_more;
                o_cmd.del_drop = !i_stat.del_more;
            end
            lifo_pkg::S_DEL_WR:  o_cmd.del_write = 1'b1;
            lifo_pkg::S_TOP_RD:  o_cmd.top_read = 1'b1;
            lifo_pkg::S_FIN:     o_cmd.out_load = i_stat.out_free;
            default:             o_cmd = '0;
        endcase
    end

`include "assert_macros.svh"

    `ASSERT_NEXT(a_top_then_fin, r_state == lifo_pkg::S_TOP_RD, r_state == lifo_pkg::S_FIN, "top read must be followed by the finish state")
    `ASSERT_IMPL(a_walk_no_accept, r_state != lifo_pkg::S_IDLE, !o_cmd.accept, "no word may be accepted during a walk")

endmodule

`default_nettype wire

// ===== design/lifo_dp.sv =====
// Datapath for the LIFO stack: entry memory, count, walk pointers, result register.
// Depends on lifo_pkg, lifo_ram and assert_macros.svh.
`default_nettype none

module lifo_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lifo_pkg::t_cmd                i_cmd,
    output lifo_pkg::t_stat                    o_stat,
    input  wire logic [lifo_pkg::ACTION_W-1:0] i_action,
    input  wire logic [lifo_pkg::VALUE_W-1:0]  i_push_value,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic signed [lifo_pkg::VALUE_W-1:0] o_top_value,
    output logic [lifo_pkg::ENTRY_W-1:0]       o_entry_count,
    output logic                               o_is_empty,
    output logic [lifo_pkg::STATUS_W-1:0]      o_status
);

    logic [lifo_pkg::CNT_W-1:0] r_count, n_count;
    logic [lifo_pkg::IDX_W-1:0] r_lo, n_lo;
    logic [lifo_pkg::IDX_W-1:0] r_hi, n_hi;
    logic [lifo_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [lifo_pkg::WIDTH-1:0] r_tmp, n_tmp;
    lifo_pkg::t_status          r_op_status, n_op_status;

    logic                               r_out_valid;
    logic signed [lifo_pkg::VALUE_W-1:0] r_top;
    logic [lifo_pkg::CNT_W-1:0]         r_count_out;
    lifo_pkg::t_status                  r_status_out;

    logic                       ram_we;
    logic [lifo_pkg::IDX_W-1:0] ram_waddr;
    logic [lifo_pkg::WIDTH-1:0] ram_wdata;
    logic                       ram_re;
    logic [lifo_pkg::IDX_W-1:0] ram_raddr;
    logic [lifo_pkg::WIDTH-1:0] ram_rdata;

    logic [lifo_pkg::CNT_W-1:0] top_pos;
    logic [lifo_pkg::CNT_W-1:0] del_pos;
    logic [lifo_pkg::CNT_W-1:0] idx_plus;
    logic                       full;
    lifo_pkg::t_action          action;

    assign action   = lifo_pkg::t_action'(i_action);
    assign top_pos  = r_count - lifo_pkg::CNT_W'(1);
    assign del_pos  = top_pos - (r_count >> 1);
    assign idx_plus = lifo_pkg::CNT_W'(r_idx) + lifo_pkg::CNT_W'(1);
    assign full     = (r_count == lifo_pkg::CNT_W'(lifo_pkg::DEPTH));

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.rev_more   = (r_lo < r_hi);
    assign o_stat.del_more   = (idx_plus < r_count);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_count[lifo_pkg::IDX_W-1:0];
        ram_wdata = i_push_value[lifo_pkg::WIDTH-1:0];
        if (i_cmd.accept && action == lifo_pkg::ACT_PUSH && !full) begin
            ram_we = 1'b1;
        end else if (i_cmd.rev_write_lo) begin
            ram_we    = 1'b1;
            ram_waddr = r_lo;
            ram_wdata = ram_rdata;
        end else if (i_cmd.rev_write_hi) begin
            ram_we    = 1'b1;
            ram_waddr = r_hi;
            ram_wdata = r_tmp;
        end else if (i_cmd.del_write) begin
            ram_we    = 1'b1;
            ram_waddr = r_idx;
            ram_wdata = ram_rdata;
        end
    end

    always_comb begin
        ram_re    = i_cmd.rev_read_lo || i_cmd.rev_read_hi || i_cmd.del_read
                    || i_cmd.top_read;
        ram_raddr = top_pos[lifo_pkg::IDX_W-1:0];
        if (i_cmd.rev_read_lo) begin
            ram_raddr = r_lo;
        end else if (i_cmd.rev_read_hi) begin
            ram_raddr = r_hi;
        end else if (i_cmd.del_read) begin
            ram_raddr = idx_plus[lifo_pkg::IDX_W-1:0];
        end
    end

    always_comb begin
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_idx       = r_idx;
        n_tmp       = r_tmp;
        n_op_status = r_op_status;
        if (i_cmd.accept) begin
            n_op_status = lifo_pkg::ST_OK;
            n_lo        = '0;
            n_hi        = top_pos[lifo_pkg::IDX_W-1:0];
            n_idx       = del_pos[lifo_pkg::IDX_W-1:0];
            case (action)
                lifo_pkg::ACT_PUSH: begin
                    if (full) begin
                        n_op_status = lifo_pkg::ST_OVERFLOW;
                    end else begin
                        n_count = r_count + lifo_pkg::CNT_W'(1);
                    end
                end
                lifo_pkg::ACT_POP: begin
                    if (r_count == '0) begin
                        n_op_status = lifo_pkg::ST_UNDERFLOW;
                    end else begin
                        n_count = top_pos;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.rev_read_hi) begin
            n_tmp = ram_rdata;
        end
        if (i_cmd.rev_write_hi) begin
            n_lo = r_lo + lifo_pkg::IDX_W'(1);
            n_hi = r_hi - lifo_pkg::IDX_W'(1);
        end
        if (i_cmd.del_write) begin
            n_idx = idx_plus[lifo_pkg::IDX_W-1:0];
        end
        if (i_cmd.del_drop) begin
            n_count = top_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_idx       <= n_idx;
        r_tmp       <= n_tmp;
        r_op_status <= n_op_status;
        if (i_cmd.out_load) begin
            r_top        <= (r_count == '0) ? '0
                            : lifo_pkg::VALUE_W'(signed'(ram_rdata));
            r_count_out  <= r_count;
            r_status_out <= r_op_status;
        end
    end

    lifo_ram #(
        .DATA_W(lifo_pkg::WIDTH),
        .DEPTH (lifo_pkg::DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_out_valid   = r_out_valid;
    assign o_top_value   = r_top;
    assign o_entry_count = lifo_pkg::ENTRY_W'(r_count_out);
    assign o_is_empty    = (r_count_out == '0);
    assign o_status      = r_status_out;

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_count_bound, r_count <= lifo_pkg::CNT_W'(lifo_pkg::DEPTH), "entry count exceeds depth")
    `ASSERT_IMPL(a_rev_order, i_cmd.rev_read_lo, r_lo < r_hi, "reverse walk read with crossed pointers")
    `ASSERT_IMPL(a_no_overwrite, i_cmd.out_load, !r_out_valid || i_out_ready, "result register overwritten before it was taken")
    `ASSERT_NEXT(a_drop_step, i_cmd.del_drop, r_count == $past(r_count) - lifo_pkg::CNT_W'(1), "delete did not remove exactly one entry")

endmodule

`default_nettype wire

// ===== design/lifo_stack_reverse_delete_middle.sv =====
// Top level of the LIFO stack with push, pop, reverse and delete-middle.
// Depends on lifo_pkg, lifo_ctrl and lifo_dp.
//
//   channel   direction   handshake                 payload
//   in        into block  i_in_valid / o_in_ready    i_action, i_push_value
//   out       from block  o_out_valid / i_out_ready  o_top_value, o_entry_count,
//                                                    o_is_empty, o_status
//
// Push and pop pass through a top read and a final step before the next acceptance,
// as do reverse and delete-middle on an empty stack. Otherwise reverse first swaps
// entry pairs from both ends inward and delete-middle first shifts the entries above
// the middle down, paced by the single read and single write port of the entry memory.
// Reset clears the count and the result valid flag; memory contents stay unknown.
// A waiting result holds the block in its final step; the next word is taken after it loads.
`default_nettype none

module lifo_stack_reverse_delete_middle (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [lifo_pkg::ACTION_W-1:0]  i_action,
    input  wire logic signed [lifo_pkg::VALUE_W-1:0] i_push_value,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic signed [lifo_pkg::VALUE_W-1:0] o_top_value,
    output logic [lifo_pkg::ENTRY_W-1:0]        o_entry_count,
    output logic                                o_is_empty,
    output logic [lifo_pkg::STATUS_W-1:0]       o_status
);

    lifo_pkg::t_cmd  cmd;
    lifo_pkg::t_stat stat;

    lifo_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_action  (i_action),
        .o_in_ready(o_in_ready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    lifo_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_action     (i_action),
        .i_push_value (i_push_value),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_top_value  (o_top_value),
        .o_entry_count(o_entry_count),
        .o_is_empty   (o_is_empty),
        .o_status     (o_status)
    );

endmodule

`default_nettype wire
